// File: sv/assert_macros.svh
// Assertion helpers for the RTL; included by the scheduler top.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/edf_pkg.sv
`default_nettype none

package edf_pkg;

  // Operation codes of an input item.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int ID_W    = 3;
  localparam int VAL_W   = 16;
  localparam int MISS_W  = 4;
  localparam int CTIME_W = 32;

  localparam logic [MISS_W-1:0] MISS_MAX = 4'd15;
  localparam logic [VAL_W-1:0]  WAIT_MAX = 16'hFFFF;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic             load;
    logic             tick;
    logic             run;
    logic [ID_W-1:0]  task_id;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] reps;
  } edf_ctl_t;

  // Fixed-width part of the selection token passed down the cell chain.
  typedef struct packed {
    logic              go;
    logic              found;
    logic [MISS_W-1:0] misses;
    logic [VAL_W-1:0]  work;
    logic [VAL_W-1:0]  burst;
  } edf_tok_t;

endpackage

`default_nettype wire

// File: sv/edf_chan_if.sv
`default_nettype none

// Input channel: one load or tick item.
interface edf_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [2:0]  task_id;
  logic [15:0] burst;
  logic [15:0] period;
  logic [15:0] repetitions;

  modport source (output valid, operation, task_id, burst, period, repetitions,
                  input ready);
  modport sink   (input valid, operation, task_id, burst, period, repetitions,
                  output ready);
endinterface

// Result channel: one result item per input item.
interface edf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  running_task;
  logic        cpu_idle;
  logic        preempted;
  logic [3:0]  misses_now;
  logic        job_done;
  logic [15:0] job_wait;
  logic        all_finished;
  logic [31:0] current_time;

  modport source (output valid, running_task, cpu_idle, preempted, misses_now,
                  job_done, job_wait, all_finished, current_time,
                  input ready);
  modport sink   (input valid, running_task, cpu_idle, preempted, misses_now,
                  job_done, job_wait, all_finished, current_time,
                  output ready);
endinterface

`default_nettype wire

// File: sv/edf_periodic_task_scheduler_top.sv
//  channel   | direction | handshake     | item
//  ----------+-----------+---------------+-------------------------------------------
//  in_chan   | sink      | valid / ready | load settings or advance one tick
//  out_chan  | source    | valid / ready | runner, idle, preemption, misses, wait
//
//  A tick item sends the selection token down the cell chain one task slot per
//  cycle, then runs the winner and posts the result. A load item goes straight
//  to posting its result.
//  Reset (rst_n low at a clock edge) clears every task slot, time and runner.
//  A held result stalls only the posting cycle; the next item is taken as soon
//  as the result sits in the output register.
`default_nettype none

`include "assert_macros.svh"

module edf_periodic_task_scheduler_top #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 32
) (
  input wire logic clk,
  input wire logic rst_n,
  edf_in_if.sink   in_chan,
  edf_out_if.source out_chan
);
  import edf_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_FINISH
  } state_t;

  state_t               state_r;
  logic [TIME_BITS-1:0] time_r;
  logic                 last_valid_r;
  logic [IDX_W-1:0]     last_idx_r;
  logic                 seed_go_r;
  logic [CTIME_W-1:0]   tcap_r;

  // Partial result of the item in flight.
  logic [ID_W-1:0]      run_task_r;
  logic                 idle_r, pre_r, done_r;
  logic [MISS_W-1:0]    miss_r;
  logic [VAL_W-1:0]     wait_r;

  // Output register.
  logic                 out_valid_r;
  logic [ID_W-1:0]      out_task_r;
  logic                 out_idle_r, out_pre_r, out_done_r, out_fin_r;
  logic [MISS_W-1:0]    out_miss_r;
  logic [VAL_W-1:0]     out_wait_r;
  logic [CTIME_W-1:0]   out_time_r;

  // Cell chain: index 0 is the seed, index MAX_TASKS the last cell's output.
  edf_tok_t             tok_a     [MAX_TASKS+1];
  logic [IDX_W-1:0]     tok_idx_a [MAX_TASKS+1];
  logic [TIME_BITS-1:0] tok_slk_a [MAX_TASKS+1];
  logic [TIME_BITS-1:0] tok_rel_a [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] forget_vec, busy_vec;

  edf_ctl_t             ctl;
  edf_tok_t             tok_last;
  logic                 in_acc, forget_hit, run_now, run_done, post_now;
  logic [TIME_BITS-1:0] span, burst_ext, wait_full;
  logic [VAL_W-1:0]     wait_val;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign tok_last      = tok_a[MAX_TASKS];
  assign run_now       = (state_r == S_SWEEP) && tok_last.go;
  // Post the result once the output register is free or drains this cycle.
  assign post_now      = (state_r == S_FINISH) && (!out_valid_r || out_chan.ready);

  always_comb begin
    ctl.load    = in_acc && (in_chan.operation == OP_LOAD);
    ctl.tick    = in_acc && (in_chan.operation == OP_TICK);
    ctl.run     = run_now && tok_last.found;
    ctl.task_id = in_chan.task_id;
    ctl.burst   = in_chan.burst;
    ctl.period  = in_chan.period;
    ctl.reps    = in_chan.repetitions;

    // Seed an empty token into the first cell.
    tok_a[0].go     = seed_go_r;
    tok_a[0].found  = 1'b0;
    tok_a[0].misses = '0;
    tok_a[0].work   = '0;
    tok_a[0].burst  = '0;
    tok_idx_a[0]    = '0;
    tok_slk_a[0]    = '0;
    tok_rel_a[0]    = '0;

    forget_hit = last_valid_r && forget_vec[last_idx_r];

    // Wait of a job that finishes this tick, clamped to the field range.
    run_done  = (tok_last.work == 16'd1);
    span      = time_r + TIME_BITS'(1) - tok_rel_a[MAX_TASKS];
    burst_ext = TIME_BITS'(tok_last.burst);
    wait_full = span - burst_ext;
    if (span <= burst_ext) begin
      wait_val = '0;
    end else if (wait_full > TIME_BITS'(WAIT_MAX)) begin
      wait_val = WAIT_MAX;
    end else begin
      wait_val = wait_full[VAL_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    edf_cell #(
      .MAX_TASKS (MAX_TASKS),
      .TIME_BITS (TIME_BITS),
      .IDX       (k)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctl           (ctl),
      .now           (time_r),
      .run_idx       (tok_idx_a[MAX_TASKS]),
      .tok_in        (tok_a[k]),
      .tok_in_idx    (tok_idx_a[k]),
      .tok_in_slack  (tok_slk_a[k]),
      .tok_in_rel    (tok_rel_a[k]),
      .tok_out       (tok_a[k+1]),
      .tok_out_idx   (tok_idx_a[k+1]),
      .tok_out_slack (tok_slk_a[k+1]),
      .tok_out_rel   (tok_rel_a[k+1]),
      .forget        (forget_vec[k]),
      .busy          (busy_vec[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      time_r       <= '0;
      last_valid_r <= 1'b0;
      last_idx_r   <= '0;
      seed_go_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // Launch the token in the cycle after a tick item is taken.
      seed_go_r <= ctl.tick;
      if (post_now) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // Capture time, clear the result and drop a runner whose slot was reloaded, released or dropped.
            tcap_r     <= CTIME_W'(time_r);
            run_task_r <= '0;
            idle_r     <= 1'b0;
            pre_r      <= 1'b0;
            done_r     <= 1'b0;
            miss_r     <= '0;
            wait_r     <= '0;
            if (forget_hit) begin
              last_valid_r <= 1'b0;
            end
            if (in_chan.operation == OP_TICK) begin
              state_r   <= S_SWEEP;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end

        S_SWEEP: begin
          // Token has passed every slot: run the winner for one unit, or mark the CPU idle.
          if (run_now) begin
            miss_r <= tok_last.misses;
            time_r <= time_r + TIME_BITS'(1);
            if (tok_last.found) begin
              run_task_r   <= ID_W'(tok_idx_a[MAX_TASKS]);
              pre_r        <= last_valid_r && (last_idx_r != tok_idx_a[MAX_TASKS]);
              done_r       <= run_done;
              wait_r       <= run_done ? wait_val : '0;
              last_valid_r <= !run_done;
              last_idx_r   <= tok_idx_a[MAX_TASKS];
            end else begin
              idle_r       <= 1'b1;
              last_valid_r <= 1'b0;
            end
            state_r <= S_FINISH;
          end
        end

        S_FINISH: begin
          // Load the output register once it is free.
          if (post_now) begin
            out_task_r  <= run_task_r;
            out_idle_r  <= idle_r;
            out_pre_r   <= pre_r;
            out_miss_r  <= miss_r;
            out_done_r  <= done_r;
            out_wait_r  <= wait_r;
            out_fin_r   <= ~|busy_vec;
            out_time_r  <= tcap_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.running_task = out_task_r;
  assign out_chan.cpu_idle     = out_idle_r;
  assign out_chan.preempted    = out_pre_r;
  assign out_chan.misses_now   = out_miss_r;
  assign out_chan.job_done     = out_done_r;
  assign out_chan.job_wait     = out_wait_r;
  assign out_chan.all_finished = out_fin_r;
  assign out_chan.current_time = out_time_r;

  `ASSERT_IMPL(a_wait_needs_done, out_valid_r && (out_wait_r != 16'd0), out_done_r, "wait without finished job")
  `ASSERT_IMPL(a_idle_no_run, out_valid_r && out_idle_r, (out_task_r == '0) && !out_pre_r && !out_done_r, "idle tick reports a runner")
  `ASSERT_NEXT(a_seed_single, seed_go_r, !seed_go_r, "seed token held for more than one cycle")
  `ASSERT_IMPL(a_token_in_sweep, tok_last.go, state_r == S_SWEEP, "token left the chain outside a tick")

endmodule

`default_nettype wire

// File: sv/edf_cell.sv
`default_nettype none

module edf_cell #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 32,
  parameter int IDX       = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire edf_pkg::edf_ctl_t             ctl,
  input  wire logic [TIME_BITS-1:0]          now,
  input  wire logic [$clog2(MAX_TASKS)-1:0]  run_idx,
  input  wire edf_pkg::edf_tok_t             tok_in,
  input  wire logic [$clog2(MAX_TASKS)-1:0]  tok_in_idx,
  input  wire logic [TIME_BITS-1:0]          tok_in_slack,
  input  wire logic [TIME_BITS-1:0]          tok_in_rel,
  output edf_pkg::edf_tok_t                  tok_out,
  output logic [$clog2(MAX_TASKS)-1:0]       tok_out_idx,
  output logic [TIME_BITS-1:0]               tok_out_slack,
  output logic [TIME_BITS-1:0]               tok_out_rel,
  output logic                               forget,
  output logic                               busy
);
  import edf_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);

  logic [VAL_W-1:0]     burst_r, period_r, reps_r, work_r;
  logic [TIME_BITS-1:0] dl_r, next_r, jrel_r;
  logic [1:0]           miss_r;

  edf_tok_t             tok_r;
  logic [IDX_W-1:0]     tok_idx_r;
  logic [TIME_BITS-1:0] tok_slack_r, tok_rel_r;

  logic                 load_hit, run_hit, rel, drop, elig, take;
  logic [VAL_W-1:0]     period_in, work1, work_nxt;
  logic [TIME_BITS-1:0] dl_rel, dl1, slack0, slack;
  logic [1:0]           miss_nxt;
  logic [MISS_W:0]      miss_sum;

  always_comb begin
    load_hit  = ctl.load && (32'(ctl.task_id) == IDX);
    run_hit   = ctl.run && (run_idx == IDX_W'(IDX));
    period_in = (ctl.period == '0) ? 16'd1 : ctl.period;

    // Release, then feasibility check against the deadline.
    rel      = (reps_r != '0) && (next_r == now);
    dl_rel   = now + TIME_BITS'(period_r);
    work1    = rel ? burst_r : work_r;
    dl1      = rel ? dl_rel : dl_r;
    slack0   = dl1 - now;
    drop     = (work1 != '0) && (TIME_BITS'(work1) > slack0);
    work_nxt = drop ? '0 : work1;
    miss_nxt = 2'(rel && (work_r != '0)) + 2'(drop);

    forget = load_hit || (ctl.tick && (rel || drop));
    busy   = (reps_r != '0) || (work_r != '0);

    // Selection: earlier deadline wins, ties keep the lower slot.
    slack    = dl_r - now;
    elig     = (work_r != '0);
    take     = elig && (!tok_in.found || (slack < tok_in_slack));
    miss_sum = {1'b0, tok_in.misses} + (MISS_W + 1)'(miss_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r   <= '0;
      period_r  <= '0;
      reps_r    <= '0;
      work_r    <= '0;
      dl_r      <= '0;
      next_r    <= '0;
      jrel_r    <= '0;
      miss_r    <= '0;
      tok_r.go    <= 1'b0;
      tok_r.found <= 1'b0;
    end else begin
      if (load_hit) begin
        burst_r  <= ctl.burst;
        period_r <= period_in;
        reps_r   <= ctl.reps;
        next_r   <= now;
        work_r   <= '0;
        miss_r   <= '0;
      end else if (ctl.tick) begin
        if (rel) begin
          reps_r <= reps_r - 16'd1;
          next_r <= dl_rel;
          dl_r   <= dl_rel;
          jrel_r <= now;
        end
        work_r <= work_nxt;
        miss_r <= miss_nxt;
      end else if (run_hit) begin
        work_r <= work_r - 16'd1;
      end

      // Hand the token to the next cell.
      tok_r.go     <= tok_in.go;
      tok_r.found  <= tok_in.found || elig;
      tok_r.misses <= miss_sum[MISS_W] ? MISS_MAX : miss_sum[MISS_W-1:0];
      if (take) begin
        tok_r.work  <= work_r;
        tok_r.burst <= burst_r;
        tok_idx_r   <= IDX_W'(IDX);
        tok_slack_r <= slack;
        tok_rel_r   <= jrel_r;
      end else begin
        tok_r.work  <= tok_in.work;
        tok_r.burst <= tok_in.burst;
        tok_idx_r   <= tok_in_idx;
        tok_slack_r <= tok_in_slack;
        tok_rel_r   <= tok_in_rel;
      end
    end
  end

  assign tok_out       = tok_r;
  assign tok_out_idx   = tok_idx_r;
  assign tok_out_slack = tok_slack_r;
  assign tok_out_rel   = tok_rel_r;

endmodule

`default_nettype wire

// File: dv/edf_deadline_checker.sv
`timescale 1ns / 1ps

module edf_deadline_checker
  import edf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  edf_in_if         in_mon,
  edf_out_if        out_mon,
  output int        fail_count,
  output int        pending,
  output int        tick_total,
  output int        load_total,
  output int        miss_total,
  output int        done_total
);

  localparam int NTASK     = 8;
  localparam int NO_RUNNER = NTASK;

  typedef struct packed {
    logic             op;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] burst;
    logic [VAL_W-1:0] period;
    logic [VAL_W-1:0] reps;
  } sched_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]    running;
    logic               idle;
    logic               pre;
    logic [MISS_W-1:0]  misses;
    logic               done;
    logic [VAL_W-1:0]   job_wait;
    logic               all_fin;
    logic [CTIME_W-1:0] ctime;
  } sched_res_t;

  // Scheduler shadow state
  logic [15:0] burst_q    [NTASK];
  logic [15:0] period_q   [NTASK];
  logic [15:0] reps_left  [NTASK];
  logic [15:0] work_q     [NTASK];
  logic [31:0] deadline_q [NTASK];
  logic [31:0] next_rel_q [NTASK];
  logic [31:0] release_q  [NTASK];
  logic [31:0] now_q;
  int unsigned last_run;

  sched_res_t pred_results[$];

  function automatic bit nothing_pending();
    for (int i = 0; i < NTASK; i++)
      if (reps_left[i] != 0 || work_q[i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic sched_res_t edf_step(sched_cmd_t c);
    sched_res_t  r;
    logic [31:0] t;
    logic [31:0] slack;
    logic [31:0] best;
    logic [31:0] span;
    logic [31:0] wt;
    int unsigned misses;
    int unsigned runner;
    r      = '0;
    t      = now_q;
    misses = 0;
    runner = NO_RUNNER;
    best   = '0;
    r.ctime = t;

    if (c.op == OP_LOAD) begin
      burst_q[c.id]    = c.burst;
      period_q[c.id]   = (c.period == 16'd0) ? 16'd1 : c.period;
      reps_left[c.id]  = c.reps;
      next_rel_q[c.id] = t;
      work_q[c.id]     = '0;
      if (last_run == c.id) last_run = NO_RUNNER;
      r.all_fin = nothing_pending();
      return r;
    end

    // release due jobs; unfinished predecessors are misses
    for (int i = 0; i < NTASK; i++) begin
      if (reps_left[i] != 0 && next_rel_q[i] == t) begin
        if (work_q[i] != 0) misses++;
        if (last_run == i) last_run = NO_RUNNER;
        work_q[i]     = burst_q[i];
        release_q[i]  = t;
        deadline_q[i] = t + period_q[i];
        next_rel_q[i] = deadline_q[i];
        reps_left[i]  = reps_left[i] - 16'd1;
      end
    end

    // drop hopeless jobs, pick the nearest deadline (lowest slot on ties)
    for (int i = 0; i < NTASK; i++) begin
      if (work_q[i] != 0) begin
        slack = deadline_q[i] - t;
        if ({16'd0, work_q[i]} > slack) begin
          work_q[i] = '0;
          misses++;
          if (last_run == i) last_run = NO_RUNNER;
        end else if (runner == NO_RUNNER || slack < best) begin
          runner = i;
          best   = slack;
        end
      end
    end

    if (runner < NO_RUNNER) begin
      r.pre = (last_run < NO_RUNNER) && (last_run != runner);
      work_q[runner] = work_q[runner] - 16'd1;
      last_run = runner;
      if (work_q[runner] == 0) begin
        span     = t + 32'd1 - release_q[runner];
        wt       = (span > {16'd0, burst_q[runner]}) ? span - burst_q[runner] : 32'd0;
        r.done   = 1'b1;
        r.job_wait = (wt > 32'hFFFF) ? WAIT_MAX : wt[15:0];
        last_run = NO_RUNNER;
      end
      r.running = runner[2:0];
    end else begin
      last_run = NO_RUNNER;
      r.idle   = 1'b1;
    end

    r.misses  = (misses > 15) ? MISS_MAX : misses[3:0];
    r.all_fin = nothing_pending();
    now_q     = t + 32'd1;
    return r;
  endfunction

  function automatic void check_field(string fname, longint unsigned e, longint unsigned a);
    if (e != a) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, fname, e, a);
    end
  endfunction

  always @(posedge clk) begin : watch
    sched_res_t exp_r;
    sched_cmd_t cmd;
    if (!rst_n) begin
      for (int i = 0; i < NTASK; i++) begin
        burst_q[i]    = '0;
        period_q[i]   = '0;
        reps_left[i]  = '0;
        work_q[i]     = '0;
        deadline_q[i] = '0;
        next_rel_q[i] = '0;
        release_q[i]  = '0;
      end
      now_q      = '0;
      last_run   = NO_RUNNER;
      pred_results.delete();
      fail_count = 0;
      tick_total = 0;
      load_total = 0;
      miss_total = 0;
      done_total = 0;
    end else begin
      // results first: nothing accepted this edge can already be answered
      if (out_mon.valid && out_mon.ready) begin
        if (pred_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with no item outstanding", $time);
        end else begin
          exp_r = pred_results.pop_front();
          check_field("running_task", exp_r.running,  out_mon.running_task);
          check_field("cpu_idle",     exp_r.idle,     out_mon.cpu_idle);
          check_field("preempted",    exp_r.pre,      out_mon.preempted);
          check_field("misses_now",   exp_r.misses,   out_mon.misses_now);
          check_field("job_done",     exp_r.done,     out_mon.job_done);
          check_field("job_wait",     exp_r.job_wait, out_mon.job_wait);
          check_field("all_finished", exp_r.all_fin,  out_mon.all_finished);
          check_field("current_time", exp_r.ctime,    out_mon.current_time);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        cmd = '{op: in_mon.operation, id: in_mon.task_id, burst: in_mon.burst,
                period: in_mon.period, reps: in_mon.repetitions};
        exp_r = edf_step(cmd);
        pred_results.push_back(exp_r);
        if (cmd.op == OP_TICK) tick_total++;
        else load_total++;
        miss_total += exp_r.misses;
        done_total += exp_r.done;
      end
    end
    pending <= pred_results.size();
  end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import edf_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // limit lies far above the slowest item plus sender gaps and receiver
  // stalls.
  localparam int STALL_LIMIT = 3000;
  localparam int RAND_ITEMS  = 260;   // per idling phase

  logic clk;
  logic rst_n;

  edf_in_if  in_if();
  edf_out_if out_if();

  // Idle rates in percent for the sender and the receiver
  int src_idle_pct;
  int sink_idle_pct;

  int fail_count;
  int pending;
  int tick_total;
  int load_total;
  int miss_total;
  int done_total;
  int quiet;

  edf_periodic_task_scheduler_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  edf_deadline_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .fail_count (fail_count),
    .pending    (pending),
    .tick_total (tick_total),
    .load_total (load_total),
    .miss_total (miss_total),
    .done_total (done_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: drop ready at random according to the current phase.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog: count edges where neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one item, idling beforehand at the sender's rate, and hold it until
  // the block takes it. Valid stays high on return so back-to-back items need
  // no second assignment in the same step.
  task automatic push_item(input logic op, input logic [2:0] id, input logic [15:0] b,
                           input logic [15:0] p, input logic [15:0] n);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.operation   <= op;
    in_if.task_id     <= id;
    in_if.burst       <= b;
    in_if.period      <= p;
    in_if.repetitions <= n;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Random load: mostly short tasks so jobs overlap and compete, now and
  // then full-width fields to toggle every bit.
  task automatic push_random_load();
    logic [2:0]  id;
    logic [15:0] b;
    logic [15:0] p;
    logic [15:0] n;
    int          sel;
    id  = 3'($urandom_range(7));
    sel = $urandom_range(9);
    b   = 16'($urandom_range(0, 5));
    p   = 16'($urandom_range(0, 16));
    n   = 16'($urandom_range(0, 12));
    if (sel == 0) begin
      b = 16'($urandom);
      p = 16'($urandom);
      n = 16'($urandom);
    end else if (sel == 1) begin
      p = 16'($urandom);
      n = 16'($urandom);
    end
    push_item(OP_LOAD, id, b, p, n);
  endtask

  initial begin
    rst_n              = 1'b0;
    src_idle_pct       = 38;
    sink_idle_pct      = 84;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_LOAD;
    in_if.task_id      = '0;
    in_if.burst        = '0;
    in_if.period       = '0;
    in_if.repetitions  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: loads ahead of the first tick release at time zero.
    push_item(OP_LOAD, 3'd0, 16'd2, 16'd5, 16'd3);
    push_item(OP_LOAD, 3'd1, 16'd1, 16'd3, 16'd2);
    // zero burst and zero period (period becomes one)
    push_item(OP_LOAD, 3'd2, 16'd0, 16'd0, 16'd2);
    // widest task: runs only when nothing nearer is ready, so it gets preempted
    push_item(OP_LOAD, 3'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // burst longer than period: dropped on its first tick
    push_item(OP_LOAD, 3'd4, 16'd4, 16'd2, 16'd1);
    repeat (8) push_item(OP_TICK, 3'd0, 16'd0, 16'd0, 16'd0);
    // reload with zero repetitions drops the pending job without a miss
    push_item(OP_LOAD, 3'd3, 16'd0, 16'd1, 16'd0);
    // every slot due each tick with one unit of work: seven misses on each tick after the first
    for (int i = 0; i < 8; i++) push_item(OP_LOAD, 3'(i), 16'd1, 16'd1, 16'd3);
    repeat (3) push_item(OP_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Random: three idling phases, ticks dominate so schedules play out.
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  = (ph == 0) ? 38 : (ph == 1) ? 84 : 0;
      sink_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 38 : 0;
      repeat (RAND_ITEMS) begin
        if ($urandom_range(99) < 18)
          push_random_load();
        else
          push_item(OP_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom),
                    16'($urandom));
      end
    end
    in_if.valid <= 1'b0;

    // Drain: wait for every outstanding result, then let the pipeline settle.
    do @(posedge clk); while (pending != 0);
    repeat (16) @(posedge clk);

    $display("Run covered %0d ticks and %0d task loads under three idling mixes,",
             tick_total, load_total);
    $display("with %0d deadline misses and %0d completed jobs.", miss_total, done_total);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/edf_pkg.sv
sv/edf_chan_if.sv
sv/edf_cell.sv
sv/edf_periodic_task_scheduler_top.sv
dv/edf_deadline_checker.sv
dv/tb.sv
